/* src/htfd_pkg.sv */
// Shared types, register codes and the CRC-8 byte step for the frame decoder.
// No dependencies.
package htfd_pkg;

    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CRC_START = CFG_IDX_W'(1);

    localparam logic [7:0] CRC_POLY_RESET  = 8'h31;
    localparam logic [7:0] CRC_START_RESET = 8'hFF;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_CRC_ERR = 1'b1;

    typedef struct packed {
        logic [7:0] crc_polynomial;
        logic [7:0] crc_start_value;
    } crc_cfg_t;

    // One checked frame handed from the front to the back
    typedef struct packed {
        logic [15:0] temp_word;
        logic [15:0] hum_word;
        logic        crc_good;
    } frame_rec_t;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic [15:0]        temp_word;
        logic [15:0]        hum_word;
        logic               frame_status;
    } result_t;

    // MSB-first CRC-8 over one byte, top bit of the generator implied
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc,
                                             input logic [7:0] data_in,
                                             input logic [7:0] poly);
        logic [7:0] r;
        r = crc ^ data_in;
        for (int k = 0; k < 8; k++)
        begin
            if (r[7])
            begin
                r = {r[6:0], 1'b0} ^ poly;
            end
            else
            begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

/* src/humidity_temperature_frame_decoder.sv */
// Top level of the temperature and humidity frame decoder.
// Depends on htfd_pkg, htfd_fifo, htfd_front and htfd_back.
//
// Input side is a queue: drive data_byte and frame_start with push; a byte is taken
// on an edge with push high and full low. Six bytes make a frame: temperature high,
// low, CRC, humidity high, low, CRC. frame_start marks byte 0 and drops any partial
// frame. One byte per cycle is sustained while full is low; the CRC step is combinational.
// Result side is a queue too: while empty is low the oldest result is on the output
// ports, taken on an edge with pop high. After the edge that takes the sixth byte, the
// frame passes the record queue and the multiply stage into the result queue, then empty falls.
// If pop is held low, results back up through the result queue, the multiply stage
// and the record queue; full rises only once a further frame record has no slot.
// Configuration writes (cfg_valid, always ready) set the CRC polynomial (index 0)
// and start value (index 1); other indexes are dropped. Write only while idle.
// Reset clears position and queues and restores polynomial 0x31 and start 0xFF.
module humidity_temperature_frame_decoder #(
    parameter int MID_DEPTH = 2,
    parameter int OUT_DEPTH = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    data_byte,
    input  logic                          frame_start,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [14:0]            temperature_centi,
    output logic [13:0]                   humidity_centi,
    output logic [15:0]                   temp_word,
    output logic [15:0]                   hum_word,
    output logic                          frame_status,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [htfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);

    import htfd_pkg::*;

    crc_cfg_t   cfg_reg;
    frame_rec_t rec_wr, rec_rd;
    result_t    result;
    logic       rec_push, rec_full, rec_pop, rec_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_polynomial  <= CRC_POLY_RESET;
            cfg_reg.crc_start_value <= CRC_START_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_CRC_POLY)
            begin
                cfg_reg.crc_polynomial <= cfg_data;
            end
            else if (cfg_index == REG_CRC_START)
            begin
                cfg_reg.crc_start_value <= cfg_data;
            end
        end
    end

    htfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .rec_full    (rec_full),
        .rec_push    (rec_push),
        .rec_data    (rec_wr)
    );

    htfd_fifo #(
        .item_t (frame_rec_t),
        .DEPTH  (MID_DEPTH)
    ) u_rec_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (rec_push),
        .wr_data (rec_wr),
        .full    (rec_full),
        .pop     (rec_pop),
        .rd_data (rec_rd),
        .empty   (rec_empty)
    );

    htfd_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_empty (rec_empty),
        .rec_pop   (rec_pop),
        .rec_data  (rec_rd),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    assign temperature_centi = result.temperature_centi;
    assign humidity_centi    = result.humidity_centi;
    assign temp_word         = result.temp_word;
    assign hum_word          = result.hum_word;
    assign frame_status      = result.frame_status;

endmodule

/* src/htfd_fifo.sv */
// Small register-based queue with push/full and pop/empty sides.
// Stand-alone; item type and depth are parameters.
module htfd_fifo #(
    parameter type item_t = logic [7:0],
    parameter int  DEPTH  = 2
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wr_data,
    output logic  full,
    input  logic  pop,
    output item_t rd_data,
    output logic  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    logic do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* src/htfd_front.sv */
// Front end: tracks byte position, runs the word CRCs and assembles frame records.
// Depends on htfd_pkg.
module htfd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  htfd_pkg::crc_cfg_t   cfg,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           data_byte,
    input  logic                 frame_start,
    input  logic                 rec_full,
    output logic                 rec_push,
    output htfd_pkg::frame_rec_t rec_data
);

    import htfd_pkg::*;

    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } pos_t;

    pos_t        pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] temp_reg, temp_next;
    logic        temp_good_reg, temp_good_next;
    logic [7:0]  hum_hi_reg, hum_hi_next;
    logic [7:0]  hum_lo_reg, hum_lo_next;

    logic       accept;
    pos_t       cur_pos;
    logic [7:0] crc_src;
    logic [7:0] crc_fed;

    // A frame-closing byte needs a record slot, so hold off whenever the queue is full
    assign full    = rec_full;
    assign accept  = push && !rec_full;
    assign cur_pos = frame_start ? POS_T_HI : pos_reg;
    assign crc_src = (cur_pos == POS_T_LO || cur_pos == POS_H_LO) ? crc_reg
                                                                  : cfg.crc_start_value;
    assign crc_fed = crc8_feed(crc_src, data_byte, cfg.crc_polynomial);

    assign rec_data.temp_word = temp_reg;
    assign rec_data.hum_word  = {hum_hi_reg, hum_lo_reg};
    assign rec_data.crc_good  = temp_good_reg && (crc_reg == data_byte);

    always_comb
    begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        temp_next      = temp_reg;
        temp_good_next = temp_good_reg;
        hum_hi_next    = hum_hi_reg;
        hum_lo_next    = hum_lo_reg;
        rec_push       = 1'b0;
        if (accept)
        begin
            unique case (cur_pos)
                POS_T_LO:
                begin
                    crc_next  = crc_fed;
                    temp_next = {temp_reg[15:8], data_byte};
                    pos_next  = POS_T_CRC;
                end
                POS_T_CRC:
                begin
                    temp_good_next = (crc_reg == data_byte);
                    crc_next       = cfg.crc_start_value;
                    pos_next       = POS_H_HI;
                end
                POS_H_HI:
                begin
                    crc_next    = crc_fed;
                    hum_hi_next = data_byte;
                    pos_next    = POS_H_LO;
                end
                POS_H_LO:
                begin
                    crc_next    = crc_fed;
                    hum_lo_next = data_byte;
                    pos_next    = POS_H_CRC;
                end
                POS_H_CRC:
                begin
                    rec_push = 1'b1;
                    crc_next = cfg.crc_start_value;
                    pos_next = POS_T_HI;
                end
                default:
                begin
                    // first byte of a frame
                    crc_next  = crc_fed;
                    temp_next = {data_byte, 8'h00};
                    pos_next  = POS_T_LO;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_T_HI;
            crc_reg       <= CRC_START_RESET;
            temp_reg      <= '0;
            temp_good_reg <= 1'b0;
            hum_hi_reg    <= '0;
            hum_lo_reg    <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            temp_reg      <= temp_next;
            temp_good_reg <= temp_good_next;
            hum_hi_reg    <= hum_hi_next;
            hum_lo_reg    <= hum_lo_next;
        end
    end

endmodule

/* src/htfd_back.sv */
// Back end: scales checked frames to hundredths and queues the results.
// Depends on htfd_pkg and htfd_fifo.
module htfd_back #(
    parameter int OUT_DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rec_empty,
    output logic                 rec_pop,
    input  htfd_pkg::frame_rec_t rec_data,
    input  logic                 pop,
    output logic                 empty,
    output htfd_pkg::result_t    result
);

    import htfd_pkg::*;

    localparam logic [30:0] T_SCALE  = 31'd17500;
    localparam logic [29:0] H_SCALE  = 30'd10000;
    localparam logic [16:0] DIVISOR  = 17'd65535;
    localparam logic [14:0] T_OFFSET = 15'd4500;

    logic        stage_valid_reg, stage_valid_next;
    logic [30:0] t_prod_reg;
    logic [29:0] h_prod_reg;
    logic [15:0] raw_t_reg;
    logic [15:0] raw_h_reg;
    logic        good_reg;

    logic    out_full;
    logic    out_push;
    logic    stage_ready;
    result_t res_next;

    logic [14:0] t_q0, t_q;
    logic [16:0] t_rem;
    logic [13:0] h_q0, h_q;
    logic [16:0] h_rem;

    assign stage_ready = !stage_valid_reg || !out_full;
    assign rec_pop     = !rec_empty && stage_ready;
    assign out_push    = stage_valid_reg && !out_full;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (rec_pop)
        begin
            stage_valid_next = 1'b1;
        end
        else if (out_push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop)
        begin
            t_prod_reg <= 31'(rec_data.temp_word) * T_SCALE;
            h_prod_reg <= 30'(rec_data.hum_word) * H_SCALE;
            raw_t_reg  <= rec_data.temp_word;
            raw_h_reg  <= rec_data.hum_word;
            good_reg   <= rec_data.crc_good;
        end
    end

    // x / 65535: q0 = x >> 16 leaves a remainder below twice the divisor
    always_comb
    begin
        t_q0  = t_prod_reg[30:16];
        t_rem = {1'b0, t_prod_reg[15:0]} + {2'b00, t_q0};
        t_q   = t_q0 + 15'(t_rem >= DIVISOR);
        h_q0  = h_prod_reg[29:16];
        h_rem = {1'b0, h_prod_reg[15:0]} + {3'b000, h_q0};
        h_q   = h_q0 + 14'(h_rem >= DIVISOR);

        res_next.temp_word = raw_t_reg;
        res_next.hum_word  = raw_h_reg;
        if (good_reg)
        begin
            res_next.temperature_centi = $signed(t_q - T_OFFSET);
            res_next.humidity_centi    = h_q;
            res_next.frame_status      = STATUS_OK;
        end
        else
        begin
            res_next.temperature_centi = '0;
            res_next.humidity_centi    = '0;
            res_next.frame_status      = STATUS_CRC_ERR;
        end
    end

    htfd_fifo #(
        .item_t (result_t),
        .DEPTH  (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (out_push),
        .wr_data (res_next),
        .full    (out_full),
        .pop     (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

/* src/htfd_checker.sv */
// Port-level checks for the frame decoder, bound to the top level.
// Depends on htfd_pkg and humidity_temperature_frame_decoder.
module htfd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic signed [14:0] temperature_centi,
    input logic [13:0]        humidity_centi,
    input logic [15:0]        temp_word,
    input logic [15:0]        hum_word,
    input logic               frame_status
);

    import htfd_pkg::*;

    // a failed frame carries zero for both converted values
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_status == STATUS_CRC_ERR) |->
            (temperature_centi == 15'sd0 && humidity_centi == 14'd0))
        else $error("converted values not zero on CRC error");

    a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_status == STATUS_OK) |->
            (temperature_centi >= -15'sd4500 && temperature_centi <= 15'sd13000 &&
             humidity_centi <= 14'd10000))
        else $error("converted value out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(temperature_centi) && $stable(humidity_centi) &&
             $stable(temp_word) && $stable(hum_word) && $stable(frame_status)))
        else $error("waiting result changed");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> empty)
        else $error("result shown straight after reset");

    // back-pressure reaches the input only once results are waiting
    a_full_implies_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("input stalled with no result waiting");

endmodule

bind humidity_temperature_frame_decoder htfd_checker u_htfd_checker (.*);

/* verif/tb.sv */
// Self-checking bench for humidity_temperature_frame_decoder: queued byte driver,
// result monitor, and an in-bench frame decoder that predicts every result.
// Depends on htfd_pkg and the decoder RTL.
module tb;
    import htfd_pkg::*;

    localparam int FRAME_LEN   = 6;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

    typedef struct packed {
        logic [7:0] b;
        logic       fs;
    } byte_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic [7:0] data_byte = 8'h00;
    logic frame_start = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic signed [14:0] temperature_centi;
    logic [13:0] humidity_centi;
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic frame_status;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0] cfg_data = 8'h00;

    humidity_temperature_frame_decoder dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .data_byte(data_byte),
        .frame_start(frame_start),
        .empty(empty),
        .pop(pop),
        .temperature_centi(temperature_centi),
        .humidity_centi(humidity_centi),
        .temp_word(temp_word),
        .hum_word(hum_word),
        .frame_status(frame_status),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // bench copy of the decoder state and registers
    logic [7:0]  cfg_poly = CRC_POLY_RESET;
    logic [7:0]  cfg_start = CRC_START_RESET;
    logic [2:0]  frame_pos = '0;
    logic [7:0]  run_crc = CRC_START_RESET;
    logic [15:0] held_temp = '0;
    logic        temp_good = 1'b0;
    logic [7:0]  held_hum_hi = '0;
    logic [7:0]  held_hum_lo = '0;

    byte_item_t pending_bytes[$];
    result_t    frames_due[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int fail_count = 0;
    int bytes_taken = 0;
    int frames_checked = 0;
    int frames_flagged = 0;
    int full_stalls = 0;
    int cfg_writes = 0;
    int cycle_count = 0;

    function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] d,
                                             logic [7:0] poly);
        logic [7:0] c;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            if (c[7] ^ d[i])
            begin
                c = {c[6:0], 1'b0} ^ poly;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // advance the bench decoder by one accepted byte
    function automatic void decode_byte(logic [7:0] b, logic fs);
        logic [2:0]  pos;
        logic [15:0] rh;
        logic        ok;
        int          t;
        result_t     r;
        pos = fs ? 3'd0 : frame_pos;
        if (pos >= FRAME_LEN)
        begin
            pos = 3'd0;
        end
        case (pos)
            3'd0:
            begin
                run_crc = crc8_step(cfg_start, b, cfg_poly);
                held_temp = {b, 8'h00};
            end
            3'd1:
            begin
                run_crc = crc8_step(run_crc, b, cfg_poly);
                held_temp[7:0] = b;
            end
            3'd2:
            begin
                temp_good = (run_crc == b);
                run_crc = cfg_start;
            end
            3'd3:
            begin
                run_crc = crc8_step(cfg_start, b, cfg_poly);
                held_hum_hi = b;
            end
            3'd4:
            begin
                run_crc = crc8_step(run_crc, b, cfg_poly);
                held_hum_lo = b;
            end
            default:
            begin
                rh = {held_hum_hi, held_hum_lo};
                ok = temp_good && (run_crc == b);
                r = '0;
                if (ok)
                begin
                    t = -4500 + int'((32'd17500 * {16'h0, held_temp}) / 32'd65535);
                    r.temperature_centi = 15'(t);
                    r.humidity_centi = 14'((32'd10000 * {16'h0, rh}) / 32'd65535);
                end
                r.temp_word = held_temp;
                r.hum_word = rh;
                r.frame_status = ok ? STATUS_OK : STATUS_CRC_ERR;
                frames_due.push_back(r);
                run_crc = cfg_start;
            end
        endcase
        frame_pos = (pos == FRAME_LEN - 1) ? 3'd0 : pos + 3'd1;
    endfunction

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // driver: one beat per handshake, items taken from pending_bytes
    always @(posedge clk or negedge rst_n)
    begin : drive_beat
        logic       next_push;
        byte_item_t item;
        if (!rst_n)
        begin
            push <= 1'b0;
            data_byte <= 8'h00;
            frame_start <= 1'b0;
        end
        else
        begin
            next_push = push;
            if (push && !full)
            begin
                decode_byte(data_byte, frame_start);
                bytes_taken++;
                next_push = 1'b0;
            end
            else if (push)
            begin
                full_stalls++;
            end
            if (!next_push && pending_bytes.size() != 0 &&
                $urandom_range(99) >= send_idle_pct)
            begin
                item = pending_bytes.pop_front();
                next_push = 1'b1;
                data_byte <= item.b;
                frame_start <= item.fs;
            end
            push <= next_push;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_requests != hold_served)
        begin
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_requests;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        result_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("result with nothing expected: temp_word %0d",
                           temp_word);
                    fail_count++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    check_field("temperature_centi", want.temperature_centi,
                                temperature_centi);
                    check_field("humidity_centi", want.humidity_centi, humidity_centi);
                    check_field("temp_word", want.temp_word, temp_word);
                    check_field("hum_word", want.hum_word, hum_word);
                    check_field("frame_status", want.frame_status, frame_status);
                    frames_checked++;
                    if (want.frame_status == STATUS_CRC_ERR)
                    begin
                        frames_flagged++;
                    end
                end
            end
            pop <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, frames_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic queue_byte(logic [7:0] b, logic fs);
        byte_item_t item;
        item.b = b;
        item.fs = fs;
        pending_bytes.push_back(item);
    endtask

    // bad[0] spoils the temperature CRC, bad[1] the humidity CRC
    task automatic queue_frame(logic [15:0] t, logic [15:0] h, logic [1:0] bad,
                               logic fs0, int len);
        logic [7:0] ct;
        logic [7:0] ch;
        logic [7:0] fr[FRAME_LEN];
        ct = crc8_step(crc8_step(cfg_start, t[15:8], cfg_poly), t[7:0], cfg_poly);
        ch = crc8_step(crc8_step(cfg_start, h[15:8], cfg_poly), h[7:0], cfg_poly);
        if (bad[0])
        begin
            ct ^= 8'($urandom_range(255, 1));
        end
        if (bad[1])
        begin
            ch ^= 8'($urandom_range(255, 1));
        end
        fr = '{t[15:8], t[7:0], ct, h[15:8], h[7:0], ch};
        for (int i = 0; i < len; i++)
        begin
            queue_byte(fr[i], (i == 0) ? fs0 : 1'b0);
        end
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001;
            3: return 16'hFFFE;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_bytes.size() != 0 || push || frames_due.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
            begin
                break;
            end
        end
        if (idx == REG_CRC_POLY)
        begin
            cfg_poly = value;
        end
        else if (idx == REG_CRC_START)
        begin
            cfg_start = value;
        end
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed frames, some with spoilt CRCs, cut short, or bare noise
    task automatic run_phase(int n_bytes, int idle_pct, int stall_pct);
        int   queued;
        int   kind;
        int   len;
        logic resync;
        @(negedge clk);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        queued = 0;
        resync = 1'b1;
        while (queued < n_bytes)
        begin
            kind = $urandom_range(99);
            if (kind < 82)
            begin
                queue_frame(pick_word(), pick_word(),
                            (kind < 72) ? 2'b00 : 2'($urandom_range(3, 1)),
                            resync | 1'($urandom_range(1)), FRAME_LEN);
                resync = 1'b0;
                queued += FRAME_LEN;
            end
            else if (kind < 91)
            begin
                len = $urandom_range(FRAME_LEN - 1, 1);
                queue_frame(pick_word(), pick_word(), 2'b00, 1'b1, len);
                resync = 1'b1;
                queued += len;
            end
            else
            begin
                len = $urandom_range(6, 1);
                for (int i = 0; i < len; i++)
                begin
                    queue_byte(8'($urandom), 1'($urandom_range(1)));
                end
                resync = 1'b1;
                queued += len;
            end
        end
        wait_drained();
    endtask

    initial
    begin : stimulus
        logic [15:0] mid_t;
        logic [7:0]  mid_hh;
        logic [7:0]  mid_hl;
        logic [7:0]  mid_poly;
        logic [7:0]  mid_start;
        logic [7:0]  mid_crc;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed frames under the reset settings
        queue_frame(16'h0000, 16'h0000, 2'b00, 1'b1, FRAME_LEN);
        queue_frame(16'hFFFF, 16'hFFFF, 2'b00, 1'b0, FRAME_LEN);
        queue_frame(16'h6666, 16'h8000, 2'b00, 1'b1, 2);
        queue_frame(16'h1234, 16'h5678, 2'b01, 1'b1, FRAME_LEN);
        queue_frame(16'h9ABC, 16'hDEF0, 2'b10, 1'b0, FRAME_LEN);
        // leave the humidity word half done across a polynomial change
        mid_t = 16'h6E3A;
        mid_hh = 8'hA5;
        mid_hl = 8'h3C;
        mid_poly = cfg_poly;
        mid_start = cfg_start;
        queue_frame(mid_t, {mid_hh, mid_hl}, 2'b00, 1'b1, 4);
        wait_drained();

        write_reg(REG_CRC_POLY, 8'h07);
        mid_crc = crc8_step(crc8_step(mid_start, mid_hh, mid_poly), mid_hl, cfg_poly);
        @(negedge clk);
        queue_byte(mid_hl, 1'b0);
        queue_byte(mid_crc, 1'b0);
        hold_requests++;
        run_phase(500, 0, 0);

        write_reg(REG_UNUSED_LO, 8'hAA);
        write_reg(REG_UNUSED_HI, 8'h55);
        write_reg(REG_CRC_POLY, 8'h00);
        write_reg(REG_CRC_START, 8'h00);
        run_phase(450, 87, 0);

        write_reg(REG_CRC_POLY, 8'hFF);
        write_reg(REG_CRC_START, 8'hFF);
        run_phase(450, 0, 87);

        write_reg(REG_CRC_POLY, CRC_POLY_RESET);
        write_reg(REG_CRC_START, 8'($urandom));
        run_phase(500, 21, 21);

        $display("%0d bytes in, %0d frames checked (%0d with CRC errors), %0d register writes",
                 bytes_taken, frames_checked, frames_flagged, cfg_writes);
        $display("input held off by full for %0d cycles, %0d mismatches",
                 full_stalls, fail_count);
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* humidity_temperature_frame_decoder.f */
src/htfd_pkg.sv
src/htfd_fifo.sv
src/htfd_front.sv
src/htfd_back.sv
src/humidity_temperature_frame_decoder.sv
src/htfd_checker.sv
verif/tb.sv
